// File: hdl/gtg_pkg.sv
// gtg_pkg: word types, fixed widths and the arctangent table of the
// go-to-goal steering unit; no dependencies
`timescale 1ns / 1ps
package gtg_pkg;

  localparam int COORD_BITS   = 12;
  localparam int HEADING_BITS = 12;
  localparam int DIFF_BITS    = COORD_BITS + 1;   // dx, dy
  localparam int ANGLE_FRAC   = 16;
  localparam int ZW           = 30;               // cordic angle accumulator
  localparam int BEAR_W       = ZW - ANGLE_FRAC;  // bearing in tenths
  localparam int ERR_W        = 14;
  localparam int MAG_W        = 12;
  localparam int DIST_W       = 13;
  localparam int SQ_W         = 2 * DIFF_BITS + 1;  // sqrt remainder and root
  localparam int SQRT_PAIRS   = (DIFF_BITS + 2) / 2;
  localparam int HALF_TURN    = 1800;
  localparam int FULL_TURN    = 3600;
  localparam int RECIP_TEN    = 6554;             // 2^16 / 10, rounded up

  localparam logic [1:0] REG_BASE_SPEED    = 2'd0;
  localparam logic [1:0] REG_TURN_LIMIT    = 2'd1;
  localparam logic [1:0] REG_NEAR_DISTANCE = 2'd2;

  localparam logic [7:0]  BASE_SPEED_RST    = 8'd150;
  localparam logic [10:0] TURN_LIMIT_RST    = 11'd900;
  localparam logic [12:0] NEAR_DISTANCE_RST = 13'd200;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]   goal_x;
    logic signed [COORD_BITS-1:0]   goal_y;
    logic signed [COORD_BITS-1:0]   here_x;
    logic signed [COORD_BITS-1:0]   here_y;
    logic signed [HEADING_BITS-1:0] heading;
  } in_word_t;

  typedef struct packed {
    logic                     action;
    logic signed [11:0]       turn_angle;
    logic [DIST_W-1:0]        distance;
    logic [7:0]               left_speed;
    logic [7:0]               right_speed;
  } out_word_t;

  // values riding along the cordic stages untouched
  typedef struct packed {
    logic signed [HEADING_BITS-1:0] heading;
    logic                           zero_vec;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 30'sd29491200;
      1:  v = 30'sd17409672;
      2:  v = 30'sd9198793;
      3:  v = 30'sd4669451;
      4:  v = 30'sd2343786;
      5:  v = 30'sd1173036;
      6:  v = 30'sd586661;
      7:  v = 30'sd293348;
      8:  v = 30'sd146676;
      9:  v = 30'sd73339;
      10: v = 30'sd36669;
      11: v = 30'sd18335;
      12: v = 30'sd9167;
      13: v = 30'sd4584;
      14: v = 30'sd2292;
      15: v = 30'sd1146;
      16: v = 30'sd573;
      17: v = 30'sd286;
      18: v = 30'sd143;
      19: v = 30'sd72;
      20: v = 30'sd36;
      21: v = 30'sd18;
      22: v = 30'sd9;
      23: v = 30'sd4;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/gtg_cordic_stage.sv
// gtg_cordic_stage: one registered vectoring cordic iteration plus, in the
// early stages, two bits of the square root; uses gtg_pkg
`timescale 1ns / 1ps
module gtg_cordic_stage #(
  parameter int IDX = 0,
  parameter int XW  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          valid_i,
  input  logic signed [XW-1:0]          x_i,
  input  logic signed [XW-1:0]          y_i,
  input  logic signed [gtg_pkg::ZW-1:0] z_i,
  input  logic [gtg_pkg::SQ_W-1:0]      rem_i,
  input  logic [gtg_pkg::SQ_W-1:0]      root_i,
  input  gtg_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic signed [XW-1:0]          x_o,
  output logic signed [XW-1:0]          y_o,
  output logic signed [gtg_pkg::ZW-1:0] z_o,
  output logic [gtg_pkg::SQ_W-1:0]      rem_o,
  output logic [gtg_pkg::SQ_W-1:0]      root_o,
  output gtg_pkg::side_t                side_o
);

  localparam logic signed [gtg_pkg::ZW-1:0] ATAN = gtg_pkg::atan_entry(IDX);

  logic                          valid_q;
  logic signed [XW-1:0]          x_d, y_d, x_q, y_q;
  logic signed [gtg_pkg::ZW-1:0] z_d, z_q;
  logic [gtg_pkg::SQ_W-1:0]      rem_d, root_d, rem_q, root_q;
  gtg_pkg::side_t                side_q;

  always_comb begin
    logic signed [XW-1:0]     xs, ys;
    logic [gtg_pkg::SQ_W-1:0] bit_v, trial;
    int                       j;
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    if (y_i < 0) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end
    rem_d  = rem_i;
    root_d = root_i;
    if (IDX >= 1 && IDX <= gtg_pkg::SQRT_PAIRS) begin
      for (int s = 0; s < 2; s++) begin
        j = 2 * (IDX - 1) + s;
        if (j <= gtg_pkg::DIFF_BITS) begin
          bit_v = gtg_pkg::SQ_W'(1) << (2 * (gtg_pkg::DIFF_BITS - j));
          trial = root_d + bit_v;
          if (rem_d >= trial) begin
            rem_d  = rem_d - trial;
            root_d = (root_d >> 1) + bit_v;
          end else begin
            root_d = root_d >> 1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// File: hdl/go_to_goal_steering_unit.sv
// go_to_goal_steering_unit: top level, input fold, cordic chain, error wrap
// and speed selection; uses gtg_pkg and gtg_cordic_stage
`timescale 1ns / 1ps
// Takes one position fix per cycle unless in_stall_o is high and returns one
// steering word per fix, in order, through two front stages (differences,
// then half-plane fold and squares), one register per cordic iteration
// (stages 1 to SQRT_PAIRS also carry two bits each of the distance square
// root), one stage for bearing rounding and error wrap, and the output
// register. Each stage holds its word until the next one is free, so bubbles
// close up under a stalled output and input is taken while a result waits.
// Configuration writes land at once; write them only while the pipe is empty.
module go_to_goal_steering_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gtg_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gtg_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [12:0]         cfg_data_i
);

  localparam int N  = CORDIC_STAGES;
  localparam int D  = gtg_pkg::DIFF_BITS;
  localparam int XW = D + N + 2;   // dx scaled by 2^N plus cordic growth

  // configuration registers
  logic [7:0]  base_speed_q;
  logic [10:0] turn_limit_q;
  logic [12:0] near_distance_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q    <= gtg_pkg::BASE_SPEED_RST;
      turn_limit_q    <= gtg_pkg::TURN_LIMIT_RST;
      near_distance_q <= gtg_pkg::NEAR_DISTANCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gtg_pkg::REG_BASE_SPEED:    base_speed_q    <= cfg_data_i[7:0];
        gtg_pkg::REG_TURN_LIMIT:    turn_limit_q    <= cfg_data_i[10:0];
        gtg_pkg::REG_NEAR_DISTANCE: near_distance_q <= cfg_data_i;
        default: ;  // unused index, ignored
      endcase
    end
  end

  // stage valids and the ready chain, back to front
  logic         v1_q, v2_q, ve_q, vo_q;
  logic [N-1:0] vc;
  logic         rdy_o, rdy_e, rdy_2, rdy_1;
  logic [N-1:0] rdy_c;

  always_comb begin
    rdy_o = !vo_q || !out_stall_i;
    rdy_e = !ve_q || rdy_o;
    rdy_c[N-1] = !vc[N-1] || rdy_e;
    for (int k = N - 2; k >= 0; k--) begin
      rdy_c[k] = !vc[k] || rdy_c[k+1];
    end
    rdy_2 = !v2_q || rdy_c[0];
    rdy_1 = !v1_q || rdy_2;
  end

  assign in_stall_o = !rdy_1;

  // front stage 1: coordinate differences
  logic signed [D-1:0]                    dx_q, dy_q;
  logic signed [gtg_pkg::HEADING_BITS-1:0] head1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy_1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_1 && in_valid_i) begin
      dx_q    <= D'(in_word_i.goal_x) - D'(in_word_i.here_x);
      dy_q    <= D'(in_word_i.goal_y) - D'(in_word_i.here_y);
      head1_q <= in_word_i.heading;
    end
  end

  // front stage 2: left half-plane turned by a half turn, squares
  logic signed [XW-1:0]          x2_d, y2_d, x2_q, y2_q;
  logic signed [gtg_pkg::ZW-1:0] z2_d, z2_q;
  logic [2*D-1:0]                sqx_q, sqy_q;
  gtg_pkg::side_t                side2_q;

  always_comb begin
    x2_d = XW'(dx_q) <<< N;
    y2_d = XW'(dy_q) <<< N;
    z2_d = '0;
    if (dx_q < 0) begin
      x2_d = -x2_d;
      y2_d = -y2_d;
      if (dy_q >= 0) begin
        z2_d = gtg_pkg::ZW'(gtg_pkg::HALF_TURN) <<< gtg_pkg::ANGLE_FRAC;
      end else begin
        z2_d = -(gtg_pkg::ZW'(gtg_pkg::HALF_TURN) <<< gtg_pkg::ANGLE_FRAC);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy_2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_2 && v1_q) begin
      x2_q             <= x2_d;
      y2_q             <= y2_d;
      z2_q             <= z2_d;
      sqx_q            <= (2*D)'(dx_q) * (2*D)'(dx_q);
      sqy_q            <= (2*D)'(dy_q) * (2*D)'(dy_q);
      side2_q.heading  <= head1_q;
      side2_q.zero_vec <= (dx_q == '0) && (dy_q == '0);
    end
  end

  // cordic chain; the first stage also adds the squares
  logic signed [XW-1:0]          cx   [N];
  logic signed [XW-1:0]          cy   [N];
  logic signed [gtg_pkg::ZW-1:0] cz   [N];
  logic [gtg_pkg::SQ_W-1:0]      crem [N];
  logic [gtg_pkg::SQ_W-1:0]      croot[N];
  gtg_pkg::side_t                cside[N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      gtg_cordic_stage #(.IDX(k), .XW(XW)) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .load_i  (rdy_c[k]),
        .valid_i (v2_q),
        .x_i     (x2_q),
        .y_i     (y2_q),
        .z_i     (z2_q),
        .rem_i   (gtg_pkg::SQ_W'(sqx_q) + gtg_pkg::SQ_W'(sqy_q)),
        .root_i  ('0),
        .side_i  (side2_q),
        .valid_o (vc[k]),
        .x_o     (cx[k]),
        .y_o     (cy[k]),
        .z_o     (cz[k]),
        .rem_o   (crem[k]),
        .root_o  (croot[k]),
        .side_o  (cside[k])
      );
    end else begin : g_next
      gtg_cordic_stage #(.IDX(k), .XW(XW)) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .load_i  (rdy_c[k]),
        .valid_i (vc[k-1]),
        .x_i     (cx[k-1]),
        .y_i     (cy[k-1]),
        .z_i     (cz[k-1]),
        .rem_i   (crem[k-1]),
        .root_i  (croot[k-1]),
        .side_i  (cside[k-1]),
        .valid_o (vc[k]),
        .x_o     (cx[k]),
        .y_o     (cy[k]),
        .z_o     (cz[k]),
        .rem_o   (crem[k]),
        .root_o  (croot[k]),
        .side_o  (cside[k])
      );
    end
  end

  // error stage: round bearing to tenths, wrap heading error once
  logic signed [gtg_pkg::ERR_W-1:0]  err_d, err_q;
  logic [gtg_pkg::MAG_W-1:0]         mag_d, mag_q;
  logic [gtg_pkg::DIST_W-1:0]        dist_q;

  always_comb begin
    logic signed [gtg_pkg::ZW-1:0]     zr;
    logic signed [gtg_pkg::BEAR_W-1:0] bear;
    zr   = cz[N-1] + (gtg_pkg::ZW'(1) <<< (gtg_pkg::ANGLE_FRAC - 1));
    bear = gtg_pkg::BEAR_W'(zr >>> gtg_pkg::ANGLE_FRAC);
    if (cside[N-1].zero_vec) begin
      bear = '0;
    end
    err_d = gtg_pkg::ERR_W'(cside[N-1].heading) - gtg_pkg::ERR_W'(bear);
    if (err_d < -gtg_pkg::ERR_W'(gtg_pkg::HALF_TURN)) begin
      err_d = err_d + gtg_pkg::ERR_W'(gtg_pkg::FULL_TURN);
    end
    if (err_d > gtg_pkg::ERR_W'(gtg_pkg::HALF_TURN)) begin
      err_d = err_d - gtg_pkg::ERR_W'(gtg_pkg::FULL_TURN);
    end
    mag_d = (err_d < 0) ? gtg_pkg::MAG_W'(-err_d) : gtg_pkg::MAG_W'(err_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (rdy_e) begin
      ve_q <= vc[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && vc[N-1]) begin
      err_q  <= err_d;
      mag_q  <= mag_d;
      dist_q <= croot[N-1][gtg_pkg::DIST_W-1:0];
    end
  end

  // output register: rotate or drive, wheel speeds
  gtg_pkg::out_word_t out_d, out_q;

  always_comb begin
    logic [24:0] prod;
    logic [9:0]  fast;
    logic [7:0]  fast_sat;
    prod     = 25'(mag_q) * 25'(gtg_pkg::RECIP_TEN);
    fast     = 10'(base_speed_q) + 10'(prod[24:16]);   // base plus whole degrees
    fast_sat = (fast > 10'd255) ? 8'd255 : fast[7:0];
    out_d.turn_angle  = err_q[11:0];
    out_d.distance    = dist_q;
    out_d.action      = 1'b0;
    out_d.left_speed  = '0;
    out_d.right_speed = '0;
    if (!(mag_q >= gtg_pkg::MAG_W'(turn_limit_q) || dist_q <= near_distance_q)) begin
      out_d.action = 1'b1;
      if (err_q > 0) begin
        out_d.left_speed  = fast_sat;
        out_d.right_speed = base_speed_q;
      end else begin
        out_d.left_speed  = base_speed_q;
        out_d.right_speed = fast_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy_o) begin
      vo_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && ve_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_word_o  = out_q;

  // rotate words carry no wheel speed
  a_rotate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.action) |->
      (out_word_o.left_speed == '0 && out_word_o.right_speed == '0))
    else $error("rotate word with nonzero speed");

  // drive only beyond the near distance
  a_drive_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.action) |-> (out_word_o.distance > near_distance_q))
    else $error("drive word inside near distance");

  // one wheel in drive always runs at base speed
  a_drive_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.action) |->
      (out_word_o.left_speed == base_speed_q || out_word_o.right_speed == base_speed_q))
    else $error("drive word without base wheel");

  // wrapped error stays within a half turn
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_word_o.turn_angle) >= -12'sd1800 &&
                     $signed(out_word_o.turn_angle) <= 12'sd1800))
    else $error("turn angle out of range");

endmodule

// File: verif/go_to_goal_steering_unit_test.sv
// go_to_goal_steering_unit_test: self-checking testbench of the go-to-goal
// steering unit; uses gtg_pkg and go_to_goal_steering_unit
`timescale 1ns / 1ps
module go_to_goal_steering_unit_test;

  // index with no register behind it, writes must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PIPE_DEPTH = 20;      // cordic stages plus four
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;

  // predicts steering words from accepted fixes and checks the results
  class steering_board;
    gtg_pkg::out_word_t due_q[$];
    logic [7:0] base_speed;
    logic [10:0] turn_limit;
    logic [12:0] near_dist;
    int errors;
    longint atan_tab[16];

    function new();
      atan_tab = '{29491200, 17409672, 9198793, 4669451, 2343786, 1173036,
                   586661, 293348, 146676, 73339, 36669, 18335, 9167, 4584,
                   2292, 1146};
      base_speed = gtg_pkg::BASE_SPEED_RST;
      turn_limit = gtg_pkg::TURN_LIMIT_RST;
      near_dist = gtg_pkg::NEAR_DISTANCE_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        gtg_pkg::REG_BASE_SPEED: base_speed = val[7:0];
        gtg_pkg::REG_TURN_LIMIT: turn_limit = val[10:0];
        gtg_pkg::REG_NEAR_DISTANCE: near_dist = val;
        default: ;
      endcase
    endfunction

    // vectoring cordic, angles in 1/65536 of a tenth of a degree
    function longint bearing(longint dx, longint dy);
      longint x, y, z, xs, ys;
      x = dx <<< 16;
      y = dy <<< 16;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      if (x < 0) begin
        z = (dy >= 0 ? gtg_pkg::HALF_TURN : -gtg_pkg::HALF_TURN) * 65536;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y < 0) begin
          x = x - ys;
          y = y + xs;
          z -= atan_tab[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z += atan_tab[i];
        end
      end
      return (z + 32768) >>> 16;
    endfunction

    function longint root_floor(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 40;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    function void note_fix(gtg_pkg::in_word_t w);
      longint dx, dy, err, mag, range_v, fast;
      gtg_pkg::out_word_t o;
      dx = longint'(w.goal_x) - longint'(w.here_x);
      dy = longint'(w.goal_y) - longint'(w.here_y);
      err = longint'(w.heading) - bearing(dx, dy);
      if (err < -gtg_pkg::HALF_TURN) err += gtg_pkg::FULL_TURN;
      if (err > gtg_pkg::HALF_TURN) err -= gtg_pkg::FULL_TURN;
      mag = err < 0 ? -err : err;
      range_v = root_floor(dx * dx + dy * dy);
      o = '0;
      o.turn_angle = err[11:0];
      o.distance = range_v[12:0];
      if (!(mag >= turn_limit || range_v <= near_dist)) begin
        o.action = 1'b1;
        fast = base_speed + mag / 10;
        if (fast > 255) fast = 255;
        o.left_speed = err > 0 ? fast[7:0] : base_speed;
        o.right_speed = err > 0 ? base_speed : fast[7:0];
      end
      due_q.push_back(o);
    endfunction

    function void check_word(gtg_pkg::out_word_t a);
      gtg_pkg::out_word_t e;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, a);
        errors++;
        return;
      end
      e = due_q.pop_front();
      if (a.action !== e.action) begin
        $display("%0t: action exp %0d got %0d", $time, e.action, a.action);
        errors++;
      end
      if (a.turn_angle !== e.turn_angle) begin
        $display("%0t: turn_angle exp %0d got %0d", $time, e.turn_angle, a.turn_angle);
        errors++;
      end
      if (a.distance !== e.distance) begin
        $display("%0t: distance exp %0d got %0d", $time, e.distance, a.distance);
        errors++;
      end
      if (a.left_speed !== e.left_speed) begin
        $display("%0t: left_speed exp %0d got %0d", $time, e.left_speed, a.left_speed);
        errors++;
      end
      if (a.right_speed !== e.right_speed) begin
        $display("%0t: right_speed exp %0d got %0d", $time, e.right_speed, a.right_speed);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  gtg_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  gtg_pkg::out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = gtg_pkg::REG_BASE_SPEED;
  logic [12:0] cfg_data_i = '0;

  steering_board board = new();
  bit hold_req = 1'b0;   // main asks the receiver for one long hold-off
  int idle_cycles = 0;

  go_to_goal_steering_unit uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: checks accepted words and drives stall
  initial begin
    int stall_left, hold_left;
    stall_left = 2;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) board.check_word(out_word_o);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = gap_len();
      end
    end
  end

  // watchdog: cycles with neither side accepting
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("go_to_goal_steering_unit_test NOT OK");
        $finish;
      end
    end
  end

  // offer one fix, valid stays high when the next one follows at once
  task automatic send_fix(gtg_pkg::in_word_t w, bit calm);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    board.note_fix(w);
  endtask

  task automatic finish_sending();
    in_valid_i <= 1'b0;
  endtask

  // drain the pipe, then allow for words still in flight
  task automatic drain();
    finish_sending();
    while (board.due_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 5) @(posedge clk_i);
  endtask

  // one write, then the write enable is dropped before anything else is driven
  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic gtg_pkg::in_word_t fix(int gx, int gy, int hx, int hy, int hd);
    gtg_pkg::in_word_t w;
    w.goal_x = gx[11:0];
    w.goal_y = gy[11:0];
    w.here_x = hx[11:0];
    w.here_y = hy[11:0];
    w.heading = hd[11:0];
    return w;
  endfunction

  // random fix: mostly in range, sometimes a short hop, sometimes raw bits
  function automatic gtg_pkg::in_word_t random_fix();
    gtg_pkg::in_word_t w;
    int r;
    w = gtg_pkg::in_word_t'({$urandom, $urandom});
    r = $urandom_range(0, 9);
    if (r < 4) begin
      w.here_x = w.goal_x + 12'($urandom_range(0, 600) - 300);
      w.here_y = w.goal_y + 12'($urandom_range(0, 600) - 300);
    end
    if (r != 9) w.heading = 12'($urandom_range(0, 3600) - 1800);
    return w;
  endfunction

  task automatic random_phase(int n);
    bit calm;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      send_fix(random_fix(), calm);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed fixes at reset settings
    send_fix(fix(0, 0, 0, 0, 0), 0);              // goal on the robot
    send_fix(fix(2047, 2047, -2048, -2048, 450), 0);
    send_fix(fix(-2048, -2048, 2047, 2047, -1350), 0);
    send_fix(fix(-2048, 2047, 2047, -2048, 1800), 0);
    send_fix(fix(2047, -2048, -2048, 2047, -1800), 0);
    send_fix(fix(-500, 0, 0, 0, 1800), 0);        // left half-plane, dy zero
    send_fix(fix(-500, -1, 0, 0, -1800), 0);      // left half-plane, dy below
    send_fix(fix(-500, 1, 0, 0, 1790), 0);
    send_fix(fix(1000, 0, 0, 0, 0), 0);           // zero error, drive
    send_fix(fix(0, 1000, 0, 0, 900), 0);
    send_fix(fix(0, 1000, 0, 0, 1), 0);
    send_fix(fix(1000, 0, 0, 0, 899), 0);
    send_fix(fix(1000, 0, 0, 0, -899), 0);
    send_fix(fix(1000, 0, 0, 0, 2047), 0);        // heading beyond range
    send_fix(fix(1000, 0, 0, 0, -2048), 0);
    send_fix(fix(-1000, 0, 0, 0, 2047), 0);
    send_fix(fix(200, 0, 0, 0, 0), 0);            // at the near distance
    send_fix(fix(201, 0, 0, 0, 0), 0);
    send_fix(fix(141, 142, 0, 0, 450), 0);
    drain();

    // default settings, with a long receiver hold-off midway
    random_phase(200);
    hold_req = 1'b1;
    random_phase(200);
    drain();

    // extremes: slow wheel stopped, widest turn limit, no near zone
    write_reg(gtg_pkg::REG_BASE_SPEED, 13'd0);
    write_reg(gtg_pkg::REG_TURN_LIMIT, 13'd1800);
    write_reg(gtg_pkg::REG_NEAR_DISTANCE, 13'd0);
    random_phase(300);
    // sender pause until every word is back
    finish_sending();
    while (board.due_q.size() != 0) @(posedge clk_i);
    random_phase(100);
    drain();

    // other extremes: always rotate
    write_reg(gtg_pkg::REG_BASE_SPEED, 13'd255);
    write_reg(gtg_pkg::REG_TURN_LIMIT, 13'd0);
    write_reg(gtg_pkg::REG_NEAR_DISTANCE, 13'd5792);
    write_reg(REG_UNUSED, 13'h1fff);
    random_phase(150);
    drain();

    // fast wheel saturating, then a few random settings
    write_reg(gtg_pkg::REG_BASE_SPEED, 13'd250);
    write_reg(gtg_pkg::REG_TURN_LIMIT, 13'd1800);
    write_reg(gtg_pkg::REG_NEAR_DISTANCE, 13'd0);
    random_phase(200);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_reg(gtg_pkg::REG_BASE_SPEED, 13'($urandom_range(0, 255)));
      write_reg(gtg_pkg::REG_TURN_LIMIT, 13'($urandom_range(0, 1800)));
      write_reg(gtg_pkg::REG_NEAR_DISTANCE, 13'($urandom_range(0, 5792)));
      if (p == 2) hold_req = 1'b1;
      random_phase(150);
      drain();
    end

    if (board.errors == 0 && board.due_q.size() == 0) begin
      $display("go_to_goal_steering_unit_test OK");
    end else begin
      $display("go_to_goal_steering_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/gtg_pkg.sv
hdl/gtg_cordic_stage.sv
hdl/go_to_goal_steering_unit.sv
verif/go_to_goal_steering_unit_test.sv
